// ===== rtl/wmd_pkg.sv =====
// Shared constants for the window mean and deviation block.
// No dependencies; the front end, back end, top level and checker refer to this package by scoped names.
package wmd_pkg;

  // Field widths of the sample and result requests
  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 8;
  localparam int MEAN_W   = 24;
  localparam int JITTER_W = 23;
  localparam int HELD_W   = 7;

  // 65536 * population variance of 16-bit samples stays below 2^46
  localparam int VAR_W  = 46;
  localparam int ROOT_W = VAR_W / 2;

  // Default window length
  localparam int DEFAULT_WINDOW = 100;

  // Depth of the queue between front and back end
  localparam int QUEUE_DEPTH = 2;

endpackage

// ===== rtl/wmd_div.sv =====
// Restoring divider, one quotient bit per clock.
// Depends on nothing; the caller guarantees the quotient fits in QW bits.
module wmd_div #(
  parameter int DVW = 32,
  parameter int DSW = 8,
  parameter int QW  = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DVW-1:0] dividend_i,
  input  logic [DSW-1:0] divisor_i,
  output logic           busy_o,
  output logic [QW-1:0]  quotient_o
);

  localparam int CTW = $clog2(QW + 1);

  logic [DSW-1:0] rem_q, dsr_q;
  logic [QW-1:0]  sh_q;
  logic [CTW-1:0] cnt_q;
  logic           busy_q;
  logic [DSW:0]   trial;
  logic           fits;

  // Bring down the next dividend bit and try the subtraction
  assign trial = {rem_q, sh_q[QW-1]};
  assign fits  = (trial >= {1'b0, dsr_q});

  // Iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CTW'(QW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CTW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: high part of the dividend seeds the partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DSW'(dividend_i >> QW);
      sh_q  <= dividend_i[QW-1:0];
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? DSW'(trial - {1'b0, dsr_q}) : trial[DSW-1:0];
      sh_q  <= {sh_q[QW-2:0], fits};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = sh_q;

endmodule

// ===== rtl/wmd_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per clock.
// Depends on nothing; VW must be even.
module wmd_sqrt #(
  parameter int VW = 46
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [VW-1:0]     radicand_i,
  output logic              busy_o,
  output logic [VW/2-1:0]   root_o
);

  localparam int RW  = VW / 2;
  localparam int CTW = $clog2(RW + 1);

  logic [VW-1:0]   rad_q;
  logic [RW+1:0]   rem_q;
  logic [RW-1:0]   root_q;
  logic [CTW-1:0]  cnt_q;
  logic            busy_q;
  logic [RW+3:0]   rem_sh;
  logic [RW+3:0]   trial;
  logic            fits;

  // Next two radicand bits against 4*root + 1
  assign rem_sh = {rem_q, rad_q[VW-1:VW-2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  // Iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CTW'(RW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CTW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[VW-3:0], 2'b00};
      rem_q  <= fits ? (RW+2)'(rem_sh - trial) : rem_sh[RW+1:0];
      root_q <= {root_q[RW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

// ===== rtl/wmd_front.sv =====
// Front end: takes samples, keeps the sample ring, count, sum and sum of squares.
// Depends on wmd_pkg; pushes (count, sum, sum of squares) to the queue.
module wmd_front #(
  parameter int WINDOW = wmd_pkg::DEFAULT_WINDOW,
  parameter int CW     = $clog2(WINDOW + 1),
  parameter int SW     = wmd_pkg::SAMPLE_W + CW,
  parameter int QSW    = 2 * wmd_pkg::SAMPLE_W + CW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [wmd_pkg::SAMPLE_W-1:0] sample_ms_i,
  output logic                        push_valid_o,
  input  logic                        push_stall_i,
  output logic [CW-1:0]               held_o,
  output logic [SW-1:0]               sum_o,
  output logic [QSW-1:0]              sqsum_o
);

  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int XW = wmd_pkg::SAMPLE_W;

  typedef enum logic [4:0] {
    F_IDLE  = 5'b00001,
    F_SQNEW = 5'b00010,
    F_ADD   = 5'b00100,
    F_SUB   = 5'b01000,
    F_PUSH  = 5'b10000
  } front_state_e;

  front_state_e state_q, state_d;

  logic [XW-1:0]   ring [WINDOW];
  logic [XW-1:0]   x_q, old_q;
  logic [2*XW-1:0] prod_q;
  logic [AW-1:0]   slot_q;
  logic [CW-1:0]   held_q;
  logic [SW-1:0]   sum_q;
  logic [QSW-1:0]  sqsum_q;
  logic            evict_q;
  logic            accept;

  assign accept = in_valid_i && (state_q == F_IDLE);

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:  if (in_valid_i) state_d = F_SQNEW;
      F_SQNEW: state_d = F_ADD;
      F_ADD:   state_d = F_SUB;
      F_SUB:   state_d = F_PUSH;
      F_PUSH:  if (!push_stall_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  // Control state and running totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      slot_q  <= '0;
      held_q  <= '0;
      sum_q   <= '0;
      sqsum_q <= '0;
      evict_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        F_IDLE: begin
          if (accept) begin
            evict_q <= (held_q == CW'(WINDOW));
            if (held_q != CW'(WINDOW)) begin
              held_q <= held_q + 1'b1;
            end
            slot_q <= (slot_q == AW'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
          end
        end
        F_ADD: begin
          sum_q   <= sum_q + SW'(x_q);
          sqsum_q <= sqsum_q + QSW'(prod_q);
        end
        F_SUB: begin
          if (evict_q) begin
            sum_q   <= sum_q - SW'(old_q);
            sqsum_q <= sqsum_q - QSW'(prod_q);
          end
        end
        default: ;
      endcase
    end
  end

  // Sample ring: read the oldest entry and overwrite it in one access
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ring[slot_q] <= sample_ms_i;
      old_q        <= ring[slot_q];
      x_q          <= sample_ms_i;
    end
  end

  // Shared squarer: new sample first, then the evicted one
  always_ff @(posedge clk_i) begin
    if (state_q == F_SQNEW) begin
      prod_q <= x_q * x_q;
    end else if (state_q == F_ADD) begin
      prod_q <= old_q * old_q;
    end
  end

  assign in_stall_o   = (state_q != F_IDLE);
  assign push_valid_o = (state_q == F_PUSH);
  assign held_o       = held_q;
  assign sum_o        = sum_q;
  assign sqsum_o      = sqsum_q;

endmodule

// ===== rtl/wmd_queue.sv =====
// Small FIFO that decouples the front end from the back end.
// Depends on nothing; valid/stall on both sides.
module wmd_queue #(
  parameter int EW    = 64,
  parameter int DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_stall_o,
  input  logic [EW-1:0] push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_stall_i,
  output logic [EW-1:0] pop_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [EW-1:0] mem [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [NW-1:0] fill_q;
  logic          do_push, do_pop;

  assign push_stall_o = (fill_q == NW'(DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign do_push      = push_valid_i && !push_stall_o;
  assign do_pop       = pop_valid_o && !pop_stall_i;

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= push_data_i;
    end
  end

  assign pop_data_o = mem[rd_q];

endmodule

// ===== rtl/wmd_back.sv =====
// Back end: turns (count, sum, sum of squares) into mean and jitter.
// Depends on wmd_pkg, wmd_div and wmd_sqrt; holds the result in an output register.
module wmd_back #(
  parameter int WINDOW = wmd_pkg::DEFAULT_WINDOW,
  parameter int CW     = $clog2(WINDOW + 1),
  parameter int SW     = wmd_pkg::SAMPLE_W + CW,
  parameter int QSW    = 2 * wmd_pkg::SAMPLE_W + CW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  output logic                          pop_stall_o,
  input  logic [CW-1:0]                 held_i,
  input  logic [SW-1:0]                 sum_i,
  input  logic [QSW-1:0]                sqsum_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [wmd_pkg::MEAN_W-1:0]    mean_q8_o,
  output logic [wmd_pkg::JITTER_W-1:0]  jitter_q8_o,
  output logic [wmd_pkg::HELD_W-1:0]    samples_held_o
);

  localparam int DW   = 2 * SW;
  localparam int CNTW = (CW > 1) ? $clog2(CW) : 1;
  localparam int FW   = wmd_pkg::FRAC_W;
  localparam int HW   = wmd_pkg::HELD_W;

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_MUL  = 6'b000010,
    B_SUB  = 6'b000100,
    B_DIV  = 6'b001000,
    B_ROOT = 6'b010000,
    B_DONE = 6'b100000
  } back_state_e;

  back_state_e state_q, state_d;

  logic [CW-1:0]   n_q, nsh_q;
  logic [SW-1:0]   s_q;
  logic [QSW-1:0]  q_q;
  logic [CNTW-1:0] cnt_q;
  logic [DW-1:0]   acc_q, ss_q;
  logic [2*CW-1:0] nn_q;
  logic [DW-1:0]   dev;
  logic            pop, out_load;
  logic            mdiv_busy, vdiv_busy, sqrt_busy;
  logic [wmd_pkg::MEAN_W-1:0] mean_quo;
  logic [wmd_pkg::VAR_W-1:0]  var_quo;
  logic [wmd_pkg::ROOT_W-1:0] root;
  logic [CW+HW-1:0] n_ext;
  logic            out_valid_q;
  logic [wmd_pkg::MEAN_W-1:0]   mean_q;
  logic [wmd_pkg::JITTER_W-1:0] jitter_q;
  logic [HW-1:0]                held_q;

  assign pop      = pop_valid_i && (state_q == B_IDLE);
  assign out_load = (state_q == B_DONE) && (!out_valid_q || !out_stall_i);
  assign dev      = acc_q - ss_q;
  assign n_ext    = (CW + HW)'(n_q);

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (pop_valid_i) state_d = B_MUL;
      B_MUL:  if (cnt_q == '0) state_d = B_SUB;
      B_SUB:  state_d = B_DIV;
      B_DIV:  if (!vdiv_busy) state_d = B_ROOT;
      B_ROOT: if (!sqrt_busy && !mdiv_busy) state_d = B_DONE;
      B_DONE: if (out_load) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // Control state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Operands, n*Q by shift-and-add over the bits of n, S*S and n*n
  always_ff @(posedge clk_i) begin
    if (pop) begin
      n_q   <= held_i;
      nsh_q <= held_i;
      s_q   <= sum_i;
      q_q   <= sqsum_i;
      acc_q <= '0;
      cnt_q <= CNTW'(CW - 1);
    end else if (state_q == B_MUL) begin
      acc_q <= {acc_q[DW-2:0], 1'b0} + (nsh_q[CW-1] ? DW'(q_q) : '0);
      nsh_q <= nsh_q << 1;
      cnt_q <= cnt_q - 1'b1;
      ss_q  <= s_q * s_q;
      nn_q  <= n_q * n_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      mean_q   <= mean_quo;
      jitter_q <= root;
      held_q   <= n_ext[HW-1:0];
    end
  end

  // Mean: 256*S / n
  wmd_div #(
    .DVW(SW + FW),
    .DSW(CW),
    .QW (wmd_pkg::MEAN_W)
  ) u_mean_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (pop),
    .dividend_i({sum_i, FW'(0)}),
    .divisor_i (held_i),
    .busy_o    (mdiv_busy),
    .quotient_o(mean_quo)
  );

  // Scaled variance: 65536*(n*Q - S*S) / (n*n)
  wmd_div #(
    .DVW(DW + 2 * FW),
    .DSW(2 * CW),
    .QW (wmd_pkg::VAR_W)
  ) u_var_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == B_SUB),
    .dividend_i({dev, (2 * FW)'(0)}),
    .divisor_i (nn_q),
    .busy_o    (vdiv_busy),
    .quotient_o(var_quo)
  );

  // Jitter: floor square root of the scaled variance
  wmd_sqrt #(
    .VW(wmd_pkg::VAR_W)
  ) u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   ((state_q == B_DIV) && !vdiv_busy),
    .radicand_i(var_quo),
    .busy_o    (sqrt_busy),
    .root_o    (root)
  );

  assign pop_stall_o    = (state_q != B_IDLE);
  assign out_valid_o    = out_valid_q;
  assign mean_q8_o      = mean_q;
  assign jitter_q8_o    = jitter_q;
  assign samples_held_o = held_q;

endmodule

// ===== rtl/window_mean_and_deviation.sv =====
// Sliding-window mean and jitter: each 16-bit millisecond sample request returns
// one result request with the mean and population standard deviation of the last
// WINDOW samples (Q.8, truncated) and the sample count. The front end takes one
// sample at a time and pushes its totals into a 2-entry queue; the back end's time
// per request is set by its serial n*Q multiply, the 46-step variance divider and
// the 23-step square root. The sample ring needs no clearing after reset; the block
// is ready at once.
module window_mean_and_deviation #(
  parameter int WINDOW = wmd_pkg::DEFAULT_WINDOW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [wmd_pkg::SAMPLE_W-1:0]  sample_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [wmd_pkg::MEAN_W-1:0]    mean_q8_o,
  output logic [wmd_pkg::JITTER_W-1:0]  jitter_q8_o,
  output logic [wmd_pkg::HELD_W-1:0]    samples_held_o
);

  localparam int CW  = $clog2(WINDOW + 1);
  localparam int SW  = wmd_pkg::SAMPLE_W + CW;
  localparam int QSW = 2 * wmd_pkg::SAMPLE_W + CW;
  localparam int EW  = CW + SW + QSW;

  logic           push_valid, push_stall, pop_valid, pop_stall;
  logic [CW-1:0]  f_held, b_held;
  logic [SW-1:0]  f_sum, b_sum;
  logic [QSW-1:0] f_sqsum, b_sqsum;
  logic [EW-1:0]  pop_data;

  // Sample intake and running totals
  wmd_front #(
    .WINDOW(WINDOW), .CW(CW), .SW(SW), .QSW(QSW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_ms_i (sample_ms_i),
    .push_valid_o(push_valid),
    .push_stall_i(push_stall),
    .held_o      (f_held),
    .sum_o       (f_sum),
    .sqsum_o     (f_sqsum)
  );

  // Totals queue
  wmd_queue #(
    .EW(EW), .DEPTH(wmd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_stall_o(push_stall),
    .push_data_i ({f_held, f_sum, f_sqsum}),
    .pop_valid_o (pop_valid),
    .pop_stall_i (pop_stall),
    .pop_data_o  (pop_data)
  );

  assign {b_held, b_sum, b_sqsum} = pop_data;

  // Statistics engine
  wmd_back #(
    .WINDOW(WINDOW), .CW(CW), .SW(SW), .QSW(QSW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_stall_o   (pop_stall),
    .held_i        (b_held),
    .sum_i         (b_sum),
    .sqsum_i       (b_sqsum),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .mean_q8_o     (mean_q8_o),
    .jitter_q8_o   (jitter_q8_o),
    .samples_held_o(samples_held_o)
  );

endmodule

// ===== rtl/wmd_checker.sv =====
// Port-level checks for window_mean_and_deviation, attached by bind.
// Depends on wmd_pkg.
module wmd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [wmd_pkg::SAMPLE_W-1:0]  sample_ms_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [wmd_pkg::MEAN_W-1:0]    mean_q8_o,
  input logic [wmd_pkg::JITTER_W-1:0]  jitter_q8_o,
  input logic [wmd_pkg::HELD_W-1:0]    samples_held_o
);

  // Front stage, two queue entries, back end and output register
  localparam int MAX_IN_FLIGHT = wmd_pkg::QUEUE_DEPTH + 3;

  logic       in_acc, out_acc;
  logic [3:0] pending_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Requests taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  // No result without a sample behind it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (pending_q != '0))
    else $error("result delivered with no sample pending");

  // Bounded number of requests in flight
  a_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 4'(MAX_IN_FLIGHT))
    else $error("more requests in flight than the pipeline holds");

  // Intake takes one sample at a time
  a_intake_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("intake took a sample while still busy");

  // Stalled sample request stays put until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(sample_ms_i)))
    else $error("stalled sample request changed");

  // Held result stays put while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(mean_q8_o)
      && $stable(jitter_q8_o) && $stable(samples_held_o)))
    else $error("stalled result changed");

endmodule

bind window_mean_and_deviation wmd_checker u_wmd_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for window_mean_and_deviation: directed table, then random samples.
// Depends on wmd_pkg and the block's sources in rtl/, checker included.
module testbench;

  localparam int SAMPLE_W        = wmd_pkg::SAMPLE_W;
  localparam int MEAN_W          = wmd_pkg::MEAN_W;
  localparam int JITTER_W        = wmd_pkg::JITTER_W;
  localparam int HELD_W          = wmd_pkg::HELD_W;
  localparam int WINDOW          = wmd_pkg::DEFAULT_WINDOW;
  localparam int RANDOM_ITEMS    = 1750;
  localparam int DIR_ROWS        = 25;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int HOLD_OFF_AFTER  = 300;
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int DRAIN_CYCLES    = 200;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [MEAN_W-1:0]   mean;
    logic [JITTER_W-1:0] jitter;
    logic [HELD_W-1:0]   held;
  } window_stats_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                typed;
    window_stats_t       want;
  } dir_row_t;

  typedef enum int {MIX_UNIFORM, MIX_SMALL, MIX_CONSTANT, MIX_EXTREME, MIX_BAND} sample_mix_e;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  // DUT ports
  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [SAMPLE_W-1:0] sample_ms_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [MEAN_W-1:0]   mean_q8_o;
  logic [JITTER_W-1:0] jitter_q8_o;
  logic [HELD_W-1:0]   samples_held_o;

  window_mean_and_deviation #(.WINDOW(WINDOW)) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_ms_i    (sample_ms_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mean_q8_o      (mean_q8_o),
    .jitter_q8_o    (jitter_q8_o),
    .samples_held_o (samples_held_o)
  );

  // Shadow copy of the window state
  logic [SAMPLE_W-1:0] shadow_ring [WINDOW];
  int unsigned         shadow_slot;
  int unsigned         shadow_held;
  longint unsigned     shadow_sum;
  longint unsigned     shadow_square_sum;

  window_stats_t stats_due [$];
  int unsigned   accepted_items;
  int unsigned   checked_results;
  int unsigned   mismatches;
  int unsigned   evictions;
  int unsigned   input_stalled_cycles;
  int unsigned   cycle_count;
  int unsigned   burst_left;

  // Directed rows: only the two results right after reset are typed in
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{16'hFFFF, 1'b1, '{24'd16776960, 23'd0,       7'd1}},
    '{16'h0000, 1'b1, '{24'd8388480,  23'd8388480, 7'd2}},
    '{16'hFFFF, 1'b0, '0}, '{16'h0000, 1'b0, '0}, '{16'h0001, 1'b0, '0},
    '{16'h8000, 1'b0, '0}, '{16'h7FFF, 1'b0, '0}, '{16'h5555, 1'b0, '0},
    '{16'hAAAA, 1'b0, '0}, '{16'h00FF, 1'b0, '0}, '{16'hFF00, 1'b0, '0},
    '{16'h1234, 1'b0, '0}, '{16'h0010, 1'b0, '0}, '{16'h0010, 1'b0, '0},
    '{16'h0010, 1'b0, '0}, '{16'h0010, 1'b0, '0}, '{16'hFFFE, 1'b0, '0},
    '{16'h0002, 1'b0, '0}, '{16'h0400, 1'b0, '0}, '{16'h0800, 1'b0, '0},
    '{16'h4000, 1'b0, '0}, '{16'h2000, 1'b0, '0}, '{16'h1000, 1'b0, '0},
    '{16'h0100, 1'b0, '0}, '{16'h0003, 1'b0, '0}
  };

  // Clock: 20 ns period
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Floor of the integer square root, digit by digit
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Take one sample into the shadow window and return the stats it yields
  function automatic window_stats_t take_sample(input logic [SAMPLE_W-1:0] sample);
    longint unsigned x, old, n, dev, nn, q1, rem, var_q16;
    window_stats_t   stats;
    x = longint'(sample);
    if (shadow_held >= WINDOW) begin
      // full window: oldest sample sits at the write slot
      old               = longint'(shadow_ring[shadow_slot]);
      shadow_sum        = shadow_sum - old;
      shadow_square_sum = shadow_square_sum - old * old;
      evictions++;
    end else begin
      shadow_held++;
    end
    shadow_ring[shadow_slot] = sample;
    shadow_sum               = shadow_sum + x;
    shadow_square_sum        = shadow_square_sum + x * x;
    shadow_slot              = (shadow_slot + 1 >= WINDOW) ? 0 : shadow_slot + 1;

    n       = longint'(shadow_held);
    dev     = n * shadow_square_sum - shadow_sum * shadow_sum;
    nn      = n * n;
    q1      = dev / nn;
    rem     = dev % nn;
    var_q16 = (q1 << 16) + ((rem << 16) / nn);
    stats.mean   = MEAN_W'((shadow_sum << 8) / n);
    stats.jitter = JITTER_W'(floor_sqrt(var_q16));
    stats.held   = HELD_W'(n);
    return stats;
  endfunction

  // Offer one sample request in a burst/gap pattern; returns once accepted
  task automatic offer_sample(input logic [SAMPLE_W-1:0] sample, input logic typed,
                              input window_stats_t want);
    int unsigned   gap;
    window_stats_t stats;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    sample_ms_i <= sample;
    do @(posedge clk_i); while (in_stall_o);
    accepted_items++;
    stats = take_sample(sample);
    stats_due.push_back(typed ? want : stats);
  endtask

  // Count cycles where the block pushes back on a pending request
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_stall_o) input_stalled_cycles++;
  end

  // Result checker
  always @(posedge clk_i) begin
    window_stats_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      checked_results++;
      if (stats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: unexpected result mean=%0d jitter=%0d held=%0d",
                   mean_q8_o, jitter_q8_o, samples_held_o);
      end else begin
        want = stats_due.pop_front();
        if (mean_q8_o !== want.mean || jitter_q8_o !== want.jitter ||
            samples_held_o !== want.held) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display({"ERROR: result %0d: mean exp %0d got %0d, ",
                      "jitter exp %0d got %0d, held exp %0d got %0d"},
                     checked_results, want.mean, mean_q8_o, want.jitter, jitter_q8_o,
                     want.held, samples_held_o);
        end
      end
    end
  end

  // Receiver stall patterns, plus one long hold-off once traffic is flowing
  initial begin
    stall_mode_e mode;
    int unsigned phase_left;
    int unsigned period;
    int unsigned hold_left;
    bit          hold_done;
    logic        stall;
    mode       = STALL_NONE;
    phase_left = 0;
    period     = 1;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && accepted_items >= HOLD_OFF_AFTER) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
      end
      if (phase_left == 0) begin
        mode       = stall_mode_e'($urandom_range(0, 3));
        phase_left = $urandom_range(20, 300);
        period     = $urandom_range(1, 8);
      end
      phase_left--;
      case (mode)
        STALL_NONE:     stall = 1'b0;
        STALL_LIGHT:    stall = ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    stall = ($urandom_range(0, 3) != 0);
        default:        stall = ((phase_left / period) % 2) == 1;
      endcase
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end
      out_stall_i <= stall;
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  // Reset, stimulus and end of run
  initial begin
    sample_mix_e         mix;
    int unsigned         mix_left;
    logic [SAMPLE_W-1:0] level;
    logic [SAMPLE_W-1:0] sample;
    int unsigned         band;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sample_ms_i = '0;
    accepted_items       = 0;
    checked_results      = 0;
    mismatches           = 0;
    evictions            = 0;
    input_stalled_cycles = 0;
    burst_left           = 0;
    shadow_slot          = 0;
    shadow_held          = 0;
    shadow_sum           = 0;
    shadow_square_sum    = 0;
    foreach (shadow_ring[i]) shadow_ring[i] = '0;
    mix      = MIX_UNIFORM;
    mix_left = 0;
    level    = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++)
      offer_sample(dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].want);

    // random segments of differently shaped sample streams
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (mix_left == 0) begin
        mix      = sample_mix_e'($urandom_range(0, 4));
        mix_left = $urandom_range(20, 160);
        level    = SAMPLE_W'($urandom);
      end
      mix_left--;
      case (mix)
        MIX_UNIFORM:  sample = SAMPLE_W'($urandom);
        MIX_SMALL:    sample = SAMPLE_W'($urandom_range(0, 15));
        MIX_CONSTANT: sample = level;
        MIX_EXTREME: begin
          case ($urandom_range(0, 5))
            0:       sample = 16'h0001;
            1:       sample = 16'hFFFE;
            2, 3:    sample = 16'hFFFF;
            default: sample = 16'h0000;
          endcase
        end
        default: begin
          band   = int'(level) + $urandom_range(0, 255);
          sample = (band > 16'hFFFF) ? 16'hFFFF : SAMPLE_W'(band);
        end
      endcase
      offer_sample(sample, 1'b0, '0);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // drain until every expected result is checked, then idle so any extra result is caught
    while (stats_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d samples (%0d with eviction from a full window), %0d results checked.",
             accepted_items, evictions, checked_results);
    $display("Input was held back for %0d cycles; %0d mismatches.",
             input_stalled_cycles, mismatches);
    if (mismatches == 0 && stats_due.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
